// ----- design/tvspm_pkg.sv -----
// Shared constants, types and the half-period note table of the three-voice tone mixer.
package tvspm_pkg;

	localparam int VOICES       = 3;
	localparam int NOTE_COUNT   = 73;
	localparam int PWM_TOP      = 24;
	localparam int PWM_PRESCALE = 4;

	localparam int CMD_W     = 2;
	localparam int CHANNEL_W = 2;
	localparam int NOTE_W    = 7;
	localparam int COUNT_W   = 16;
	localparam int DUTY_W    = 5;
	localparam int LEVEL_W   = 3;
	localparam int VOLUME_W  = 2;
	localparam int PWM_W     = 5;
	localparam int PRE_W     = 2;

	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PLAY    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SILENCE = 2'd2;

	localparam logic [VOLUME_W-1:0] VOLUME_RESET = 2'd2;

	localparam logic [COUNT_W-1:0] HALF_PERIOD_ROM [NOTE_COUNT] = '{
		16'd38222, 16'd36076, 16'd34051, 16'd32140, 16'd30336, 16'd28634, 16'd27026,
		16'd25510, 16'd24078, 16'd22726, 16'd21451, 16'd20247,
		16'd19110, 16'd18038, 16'd17025, 16'd16070, 16'd15168, 16'd14316, 16'd13513,
		16'd12754, 16'd12038, 16'd11363, 16'd10725, 16'd10123,
		16'd9555, 16'd9018, 16'd8512, 16'd8034, 16'd7583, 16'd7158, 16'd6756,
		16'd6377, 16'd6019, 16'd5681, 16'd5362, 16'd5061,
		16'd4777, 16'd4509, 16'd4256, 16'd4017, 16'd3791, 16'd3578, 16'd3377,
		16'd3188, 16'd3009, 16'd2840, 16'd2680, 16'd2530,
		16'd2388, 16'd2254, 16'd2127, 16'd2008, 16'd1895, 16'd1789, 16'd1688,
		16'd1593, 16'd1504, 16'd1419, 16'd1340, 16'd1264,
		16'd1193, 16'd1126, 16'd1063, 16'd1003, 16'd947, 16'd894, 16'd844,
		16'd796, 16'd751, 16'd709, 16'd669, 16'd632, 16'd596
	};

	typedef struct packed {
		logic tick;
		logic play;
		logic stop;
	} voice_ctrl_t;

	typedef struct packed {
		logic tick;
		logic clear_levels;
		logic silence;
	} mix_ctrl_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty;
		logic               high;
		logic [LEVEL_W-1:0] levels;
	} mix_result_t;

	// Clamp out-of-range notes to the last table entry.
	function automatic logic [COUNT_W-1:0] half_period(input logic [NOTE_W-1:0] note);
		logic [NOTE_W-1:0] idx;
		idx = note;
		if (note >= NOTE_W'(NOTE_COUNT)) begin
			idx = NOTE_W'(NOTE_COUNT - 1);
		end
		return HALF_PERIOD_ROM[idx];
	endfunction

endpackage

// ----- design/three_voice_square_tone_pwm_mixer.sv -----
// Top level: request register, voices, mixer and result register.
//
//  channel   direction  handshake             payload
//  request   in         in_valid / in_stall   command, channel, note_on, note
//  result    out        out_valid / out_stall duty, pwm_out, pwm_out_inverted, voice_levels
//  config    in         cfg_we                cfg_wdata (volume)
//
// A result is registered from each accepted request; one request per cycle while no
// stalled result holds. The path is one request register plus one result register around
// a single combinational update of the voice counters and the mixer. Reset clears the
// valid bits, voices and mixer and sets the volume to two; no clearing pass is needed.
// A stalled result holds; a full request register then holds too and in_stall rises.
module three_voice_square_tone_pwm_mixer import tvspm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CMD_W-1:0]     command,
	input  logic [CHANNEL_W-1:0] channel,
	input  logic                 note_on,
	input  logic [NOTE_W-1:0]    note,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DUTY_W-1:0]    duty,
	output logic                 pwm_out,
	output logic                 pwm_out_inverted,
	output logic [LEVEL_W-1:0]   voice_levels,
	input  logic                 cfg_we,
	input  logic [VOLUME_W-1:0]  cfg_wdata
);

	logic                 valid_s1;
	logic [CMD_W-1:0]     command_s1;
	logic [CHANNEL_W-1:0] channel_s1;
	logic                 note_on_s1;
	logic [NOTE_W-1:0]    note_s1;
	logic [VOLUME_W-1:0]  volume_q;

	logic                 valid_s2;
	mix_result_t          result_s2;
	mix_result_t          result;

	logic                 advance;
	logic                 is_tick;
	logic                 play_hit;
	logic [COUNT_W-1:0]   compare;
	logic [VOICES-1:0]    toggle;
	mix_ctrl_t            mix_ctrl;

	assign advance  = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= VOLUME_RESET;
		end else if (cfg_we) begin
			volume_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			channel_s1 <= channel;
			note_on_s1 <= note_on;
			note_s1    <= note;
		end
	end

	assign is_tick  = advance && (command_s1 == CMD_TICK);
	// drop play or stop requests aimed past the last voice
	assign play_hit = advance && (command_s1 == CMD_PLAY) &&
	                  ({1'b0, channel_s1} < (CHANNEL_W+1)'(VOICES));
	assign compare  = half_period(note_s1);

	for (genvar c = 0; c < VOICES; c++) begin : g_voice
		voice_ctrl_t vctrl;
		logic        hit;

		assign hit        = play_hit && (channel_s1 == CHANNEL_W'(c));
		assign vctrl.tick = is_tick;
		assign vctrl.play = hit && note_on_s1;
		assign vctrl.stop = (hit && !note_on_s1) ||
		                    (advance && (command_s1 == CMD_SILENCE));

		tvspm_voice u_voice (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (vctrl),
			.compare (compare),
			.toggle  (toggle[c])
		);
	end

	assign mix_ctrl.tick         = is_tick;
	assign mix_ctrl.clear_levels = play_hit && !note_on_s1;
	assign mix_ctrl.silence      = advance && (command_s1 == CMD_SILENCE);

	tvspm_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.ctrl    (mix_ctrl),
		.toggle  (toggle),
		.volume  (volume_q),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid        = valid_s2;
	assign duty             = result_s2.duty;
	assign pwm_out          = result_s2.high;
	assign pwm_out_inverted = !result_s2.high;
	assign voice_levels     = result_s2.levels;

endmodule

// ----- design/tvspm_voice.sv -----
// One square-wave voice: tick counter, compare value and enable.
module tvspm_voice import tvspm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  voice_ctrl_t        ctrl,
	input  logic [COUNT_W-1:0] compare,
	output logic               toggle
);

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] compare_q;
	logic               enable_q;

	assign toggle = ctrl.tick && enable_q && (count_q == compare_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			compare_q <= '0;
			enable_q  <= 1'b0;
		end else begin
			if (ctrl.tick && enable_q) begin
				count_q <= toggle ? '0 : count_q + 1'b1;
			end
			// keep the count on a new note, it runs on to the new compare value
			if (ctrl.play) begin
				compare_q <= compare;
				enable_q  <= 1'b1;
			end else if (ctrl.stop) begin
				enable_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/tvspm_mix.sv -----
// Level bits, duty computation and the prescaled PWM counter.
module tvspm_mix import tvspm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  mix_ctrl_t           ctrl,
	input  logic [VOICES-1:0]   toggle,
	input  logic [VOLUME_W-1:0] volume,
	output mix_result_t         result
);

	logic [LEVEL_W-1:0] levels_q, levels_d;
	logic [DUTY_W-1:0]  duty_q, duty_d;
	logic [PWM_W-1:0]   pwm_q, pwm_d;
	logic [PRE_W-1:0]   pre_q, pre_d;
	logic [1:0]         ones;

	always_comb begin
		levels_d = levels_q;
		if (ctrl.silence || ctrl.clear_levels) begin
			levels_d = '0;
		end else if (ctrl.tick) begin
			levels_d = levels_q ^ LEVEL_W'(toggle);
		end
	end

	assign ones = {1'b0, levels_d[0]} + {1'b0, levels_d[1]} + {1'b0, levels_d[2]};

	always_comb begin
		duty_d = duty_q;
		if (ctrl.silence) begin
			duty_d = '0;
		end else if (ctrl.tick && (|toggle)) begin
			duty_d = DUTY_W'({3'b000, ones} << volume);
		end
	end

	always_comb begin
		pre_d = pre_q;
		pwm_d = pwm_q;
		if (ctrl.tick) begin
			if (pre_q >= PRE_W'(PWM_PRESCALE - 1)) begin
				pre_d = '0;
				pwm_d = (pwm_q >= PWM_W'(PWM_TOP)) ? '0 : pwm_q + 1'b1;
			end else begin
				pre_d = pre_q + 1'b1;
			end
		end
	end

	assign result.duty   = duty_d;
	assign result.high   = pwm_d < duty_d;
	assign result.levels = levels_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= '0;
			duty_q   <= '0;
			pwm_q    <= '0;
			pre_q    <= '0;
		end else if (advance) begin
			levels_q <= levels_d;
			duty_q   <= duty_d;
			pwm_q    <= pwm_d;
			pre_q    <= pre_d;
		end
	end

endmodule

// ----- design/tvspm_checker.sv -----
// Port-level checks of the tone mixer and their binding to the top level.
module tvspm_checker import tvspm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [DUTY_W-1:0]    duty,
	input logic                 pwm_out,
	input logic                 pwm_out_inverted
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty))
		else $error("result dropped or changed while stalled");

	a_inverted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pwm_out_inverted != pwm_out))
		else $error("inverted drive is not the complement");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty <= DUTY_W'(PWM_TOP)))
		else $error("duty beyond the PWM period");

	a_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (duty == '0) |-> !pwm_out)
		else $error("drive high with zero duty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled without a stalled result");

endmodule

bind three_voice_square_tone_pwm_mixer tvspm_checker u_tvspm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.duty             (duty),
	.pwm_out          (pwm_out),
	.pwm_out_inverted (pwm_out_inverted)
);

// ----- tb/three_voice_square_tone_pwm_mixer_test.sv -----
// Self-checking testbench for the three-voice square-tone PWM mixer.
module three_voice_square_tone_pwm_mixer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tvspm_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int PHASES       = 12;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 1_000_000;

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [CHANNEL_W-1:0] ch;
		logic                 on;
		logic [NOTE_W-1:0]    nt;
	} tone_request_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty;
		logic               pwm;
		logic               pwm_n;
		logic [LEVEL_W-1:0] levels;
	} mix_snapshot_t;

	typedef struct packed {
		tone_request_t req;
		logic          typed;
		mix_snapshot_t want;
	} directed_row_t;

	localparam mix_snapshot_t SILENT = '{5'd0, 1'b0, 1'b1, 3'd0};

	// No voice can toggle this early, so every typed row reads back silent.
	localparam int DIRECTED_ROWS = 19;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{'{CMD_TICK,    2'd0, 1'b0, 7'd0},   1'b1, SILENT},
		'{'{CMD_UNUSED,  2'd3, 1'b1, 7'd127}, 1'b1, SILENT},
		'{'{CMD_PLAY,    2'd0, 1'b1, 7'd0},   1'b1, SILENT},
		'{'{CMD_PLAY,    2'd1, 1'b1, 7'd72},  1'b1, SILENT},
		'{'{CMD_PLAY,    2'd2, 1'b1, 7'd127}, 1'b1, SILENT},
		'{'{CMD_PLAY,    2'd3, 1'b1, 7'd10},  1'b1, SILENT},
		'{'{CMD_TICK,    2'd1, 1'b1, 7'd0},   1'b0, SILENT},
		'{'{CMD_TICK,    2'd2, 1'b0, 7'h55},  1'b0, SILENT},
		'{'{CMD_PLAY,    2'd1, 1'b0, 7'h2a},  1'b1, SILENT},
		'{'{CMD_PLAY,    2'd3, 1'b0, 7'd0},   1'b1, SILENT},
		'{'{CMD_SILENCE, 2'd1, 1'b1, 7'd99},  1'b1, SILENT},
		'{'{CMD_PLAY,    2'd0, 1'b1, 7'd72},  1'b1, SILENT},
		'{'{CMD_PLAY,    2'd0, 1'b1, 7'd73},  1'b1, SILENT},
		'{'{CMD_PLAY,    2'd1, 1'b1, 7'd71},  1'b1, SILENT},
		'{'{CMD_TICK,    2'd3, 1'b1, 7'h7f},  1'b0, SILENT},
		'{'{CMD_PLAY,    2'd2, 1'b0, 7'd1},   1'b1, SILENT},
		'{'{CMD_SILENCE, 2'd0, 1'b0, 7'd0},   1'b1, SILENT},
		'{'{CMD_TICK,    2'd0, 1'b0, 7'd0},   1'b0, SILENT},
		'{'{CMD_UNUSED,  2'd0, 1'b0, 7'd0},   1'b1, SILENT}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [CMD_W-1:0]     command;
	logic [CHANNEL_W-1:0] channel;
	logic                 note_on;
	logic [NOTE_W-1:0]    note;
	logic                 out_valid;
	logic                 out_stall;
	logic [DUTY_W-1:0]    duty;
	logic                 pwm_out;
	logic                 pwm_out_inverted;
	logic [LEVEL_W-1:0]   voice_levels;
	logic                 cfg_we;
	logic [VOLUME_W-1:0]  cfg_wdata;

	// mixer state as the block should hold it
	logic [VOLUME_W-1:0] m_volume;
	logic [COUNT_W-1:0]  m_count [VOICES];
	logic [COUNT_W-1:0]  m_compare [VOICES];
	logic                m_enable [VOICES];
	logic [LEVEL_W-1:0]  m_levels;
	logic [DUTY_W-1:0]   m_duty;
	logic [PWM_W-1:0]    m_pwm;
	logic [PRE_W-1:0]    m_prescale;

	mix_snapshot_t mix_due [$];
	int            mismatches = 0;
	int            requests_sent = 0;
	int            toggle_events = 0;
	int            burst_left = 0;
	int            cycles = 0;
	logic [DUTY_W-1:0] peak_duty = '0;
	logic          hold_off_req;

	three_voice_square_tone_pwm_mixer i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.channel          (channel),
		.note_on          (note_on),
		.note             (note),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.duty             (duty),
		.pwm_out          (pwm_out),
		.pwm_out_inverted (pwm_out_inverted),
		.voice_levels     (voice_levels),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, mix_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic mix_snapshot_t mixer_step(input tone_request_t req);
		mix_snapshot_t snap;
		logic          toggled;
		int            c;
		int            ones;
		toggled = 1'b0;
		case (req.cmd)
			CMD_TICK: begin
				for (c = 0; c < VOICES; c++) begin
					if (m_enable[c]) begin
						if (m_count[c] == m_compare[c]) begin
							m_count[c] = '0;
							m_levels[c] = ~m_levels[c];
							toggled = 1'b1;
							toggle_events++;
						end else begin
							m_count[c] = m_count[c] + 1'b1;
						end
					end
				end
				if (toggled) begin
					ones = int'(m_levels[0]) + int'(m_levels[1]) + int'(m_levels[2]);
					m_duty = DUTY_W'(ones << m_volume);
				end
				if (int'(m_prescale) + 1 >= PWM_PRESCALE) begin
					m_prescale = '0;
					m_pwm = (int'(m_pwm) >= PWM_TOP) ? '0 : m_pwm + 1'b1;
				end else begin
					m_prescale = m_prescale + 1'b1;
				end
			end
			CMD_PLAY: begin
				// drop requests for a channel that does not exist
				if (int'(req.ch) < VOICES) begin
					if (req.on) begin
						m_compare[req.ch] = (int'(req.nt) >= NOTE_COUNT) ?
							HALF_PERIOD_ROM[NOTE_COUNT-1] : HALF_PERIOD_ROM[req.nt];
						m_enable[req.ch] = 1'b1;
					end else begin
						// stop keeps the duty until the next toggle
						m_enable[req.ch] = 1'b0;
						m_levels = '0;
					end
				end
			end
			CMD_SILENCE: begin
				for (c = 0; c < VOICES; c++) begin
					m_enable[c] = 1'b0;
				end
				m_levels = '0;
				m_duty = '0;
			end
			default: begin
			end
		endcase
		snap.duty = m_duty;
		snap.pwm = (m_pwm < m_duty);
		snap.pwm_n = ~snap.pwm;
		snap.levels = m_levels;
		return snap;
	endfunction

	function automatic tone_request_t random_fields(input logic [CMD_W-1:0] cmd);
		tone_request_t r;
		r.cmd = cmd;
		r.ch = CHANNEL_W'($urandom_range(0, 3));
		r.on = 1'($urandom_range(0, 1));
		r.nt = NOTE_W'($urandom_range(0, 127));
		return r;
	endfunction

	// Called and returns at a falling edge; sender idles between some bursts.
	task automatic issue_request(input tone_request_t req, input logic typed,
			input mix_snapshot_t typed_want);
		mix_snapshot_t predicted;
		int            gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= req.cmd;
		channel <= req.ch;
		note_on <= req.on;
		note <= req.nt;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predicted = mixer_step(req);
		mix_due.push_back(typed ? typed_want : predicted);
		requests_sent++;
		@(negedge clk);
	endtask

	// Write the volume only once every pending result is out.
	task automatic write_volume(input logic [VOLUME_W-1:0] v);
		in_valid <= 1'b0;
		while (mix_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		m_volume = v;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		mix_snapshot_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (mix_due.size() == 0) begin
				$error("result with no request pending: duty %0d levels %0d", duty, voice_levels);
				mismatches++;
			end else begin
				want = mix_due.pop_front();
				if (duty > peak_duty) begin
					peak_duty = duty;
				end
				if (duty !== want.duty) begin
					$error("duty: expected %0d, got %0d", want.duty, duty);
					mismatches++;
				end
				if (pwm_out !== want.pwm) begin
					$error("pwm_out: expected %0d, got %0d", want.pwm, pwm_out);
					mismatches++;
				end
				if (pwm_out_inverted !== want.pwm_n) begin
					$error("pwm_out_inverted: expected %0d, got %0d", want.pwm_n,
						pwm_out_inverted);
					mismatches++;
				end
				if (voice_levels !== want.levels) begin
					$error("voice_levels: expected %0d, got %0d", want.levels, voice_levels);
					mismatches++;
				end
			end
		end
	end

	// Receiver: stall pattern of its own, plus one long hold-off on request.
	initial begin : receiver
		int   span;
		int   mode;
		logic hold_done;
		out_stall = 1'b0;
		span = 0;
		mode = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
			end else if (span == 0) begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(20, 200);
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ((span % 5) < 2);
				endcase
				span--;
				@(negedge clk);
			end
		end
	end

	initial begin : stimulus
		tone_request_t req;
		int            p;
		int            k;
		int            run;
		int            pick;
		int            ticks_sent;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_TICK;
		channel = '0;
		note_on = 1'b0;
		note = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_off_req = 1'b0;
		ticks_sent = 0;
		m_volume = VOLUME_RESET;
		for (k = 0; k < VOICES; k++) begin
			m_count[k] = '0;
			m_compare[k] = '0;
			m_enable[k] = 1'b0;
		end
		m_levels = '0;
		m_duty = '0;
		m_pwm = '0;
		m_prescale = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < DIRECTED_ROWS; k++) begin
			issue_request(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].want);
		end

		for (p = 0; p < PHASES; p++) begin
			write_volume((p < 4) ? VOLUME_W'(3 - p) : VOLUME_W'($urandom_range(0, 3)));
			if ($urandom_range(0, 2) == 0) begin
				issue_request(random_fields(CMD_SILENCE), 1'b0, SILENT);
			end
			// start voices mostly on the seven shortest half-periods so their counts can reach a toggle across phases
			repeat ($urandom_range(1, VOICES)) begin
				req = random_fields(CMD_PLAY);
				req.on = 1'b1;
				req.ch = CHANNEL_W'($urandom_range(0, VOICES - 1));
				if ($urandom_range(0, 7) != 0) begin
					req.nt = NOTE_W'($urandom_range(NOTE_COUNT - 7, NOTE_COUNT - 1));
				end
				issue_request(req, 1'b0, SILENT);
			end
			run = $urandom_range(60, 120);
			for (k = 0; k < run; k++) begin
				if (p == 1 && k == 40) begin
					hold_off_req = 1'b1;
				end
				pick = $urandom_range(0, 999);
				if (pick < 993) begin
					req = random_fields(CMD_TICK);
					ticks_sent++;
				end else if (pick < 996) begin
					req = random_fields(CMD_PLAY);
				end else if (pick < 999) begin
					req = random_fields(CMD_UNUSED);
				end else begin
					req = random_fields(CMD_SILENCE);
				end
				issue_request(req, 1'b0, SILENT);
			end
		end

		in_valid <= 1'b0;
		while (mix_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("%0d requests (%0d random ticks) over %0d volume phases, %0d cycles",
			requests_sent, ticks_sent, PHASES, cycles);
		$display("%0d voice toggles predicted, duty peaked at %0d, %0d field mismatches",
			toggle_events, peak_duty, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
